>>> rtl/wbms_pkg.sv
// ----------------------------------------------------------------------------
// Write buffer package
// Shared widths, codes and types for the write buffer with match stall.
// ----------------------------------------------------------------------------
package wbms_pkg;

  localparam int DEPTH     = 8;
  localparam int ADDR_W    = 48;
  localparam int TAG_W     = 8;
  localparam int SLOT_W    = 2;
  localparam int OCC_W     = 4;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CFG_IDX_W = 1;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_L1_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_MASK = 1'b1;

  localparam logic [ADDR_W-1:0] L1_MASK_RESET = 48'hFFFF_FFFF_FFE0;
  localparam logic [ADDR_W-1:0] L2_MASK_RESET = 48'hFFFF_FFFF_FFC0;

  // item modes
  localparam logic MODE_CYCLE = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              req_valid;
    logic              req_is_write;
    logic [ADDR_W-1:0] req_addr;
    logic [TAG_W-1:0]  req_tag;
    logic [SLOT_W-1:0] l2_free_slots;
  } req_t;

  typedef struct packed {
    logic              drain_valid;
    logic [TAG_W-1:0]  drain_tag;
    logic [ADDR_W-1:0] drain_addr;
    logic              drain_cohe_release;
    logic              req_taken;
    logic              req_forwarded;
    logic              stall_on_match;
    logic              stall_full;
    logic              probe_hit;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic mark;
  } cell_ctrl_t;

  typedef struct packed {
    logic             shift;
    logic [DEPTH-1:0] load_vec;
    logic [DEPTH-1:0] mark_vec;
  } chain_ctrl_t;

  typedef struct packed {
    logic [DEPTH-1:0] vld_vec;
    logic [DEPTH-1:0] l1_hit_vec;
    logic [DEPTH-1:0] l2_hit_vec;
    logic             head_cohe;
    entry_t           head;
  } chain_stat_t;

endpackage

>>> rtl/wbms_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one buffer item.
// ----------------------------------------------------------------------------
interface wbms_req_if import wbms_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wbms_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface wbms_rsp_if import wbms_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wbms_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel: index and write data.
// ----------------------------------------------------------------------------
interface wbms_cfg_if import wbms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/wbms_cell.sv
// ----------------------------------------------------------------------------
// Write buffer cell
// One buffer slot: shifts from its younger neighbor, loads, marks, compares.
// ----------------------------------------------------------------------------
module wbms_cell import wbms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic              nbr_vld,
  input  logic              nbr_cohe,
  input  entry_t            nbr_ent,
  input  entry_t            load_ent,
  input  logic [ADDR_W-1:0] cmp_addr,
  input  logic [ADDR_W-1:0] l1_mask,
  input  logic [ADDR_W-1:0] l2_mask,
  output logic              vld,
  output logic              cohe,
  output entry_t            ent,
  output logic              l1_hit,
  output logic              l2_hit
);

  logic   vld_next;
  logic   cohe_next;
  entry_t ent_next;

  always_comb begin
    vld_next  = vld;
    cohe_next = cohe;
    ent_next  = ent;
    if (ctrl.shift) begin
      vld_next  = nbr_vld;
      cohe_next = nbr_cohe;
      ent_next  = nbr_ent;
    end
    if (ctrl.load) begin
      vld_next  = 1'b1;
      cohe_next = 1'b0;
      ent_next  = load_ent;
    end
    if (ctrl.mark) begin
      cohe_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      cohe <= 1'b0;
    end else begin
      vld  <= vld_next;
      cohe <= cohe_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  assign l1_hit = ((cmp_addr ^ ent.addr) & l1_mask) == '0;
  assign l2_hit = ((cmp_addr ^ ent.addr) & l2_mask) == '0;

endmodule

>>> rtl/wbms_chain.sv
// ----------------------------------------------------------------------------
// Write buffer cell row
// Row of slots, oldest write at cell zero; a drain shifts the row by one.
// ----------------------------------------------------------------------------
module wbms_chain import wbms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  chain_ctrl_t       ctrl,
  input  entry_t            load_ent,
  input  logic [ADDR_W-1:0] cmp_addr,
  input  logic [ADDR_W-1:0] l1_mask,
  input  logic [ADDR_W-1:0] l2_mask,
  output chain_stat_t       stat
);

  logic   vld  [DEPTH];
  logic   cohe [DEPTH];
  entry_t ent  [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_t cc;
      logic       n_vld;
      logic       n_cohe;
      entry_t     n_ent;

      assign cc.shift = ctrl.shift;
      assign cc.load  = ctrl.load_vec[i];
      assign cc.mark  = ctrl.mark_vec[i];

      if (i == DEPTH - 1) begin : g_last
        assign n_vld  = 1'b0;
        assign n_cohe = 1'b0;
        assign n_ent  = '0;
      end else begin : g_mid
        assign n_vld  = vld[i+1];
        assign n_cohe = cohe[i+1];
        assign n_ent  = ent[i+1];
      end

      wbms_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cc),
        .nbr_vld  (n_vld),
        .nbr_cohe (n_cohe),
        .nbr_ent  (n_ent),
        .load_ent (load_ent),
        .cmp_addr (cmp_addr),
        .l1_mask  (l1_mask),
        .l2_mask  (l2_mask),
        .vld      (vld[i]),
        .cohe     (cohe[i]),
        .ent      (ent[i]),
        .l1_hit   (stat.l1_hit_vec[i]),
        .l2_hit   (stat.l2_hit_vec[i])
      );

      assign stat.vld_vec[i] = vld[i];
    end
  endgenerate

  assign stat.head_cohe = cohe[0];
  assign stat.head      = ent[0];

endmodule

>>> rtl/write_buffer_with_match_stall.sv
// ----------------------------------------------------------------------------
// Write buffer with match stall
// FIFO of writes between a write-through L1 and L2, with read stall on match.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns its result in the next cycle
// from an output register; the input stays ready whenever that register is
// empty or being taken in the same cycle, so a full rate of one item per
// cycle is sustained while rsp is ready. The buffer is a row of DEPTH cells
// holding the writes oldest first: a drain shifts every cell toward the head
// at once, a write loads the first free cell, and every cell compares its
// address with the request under the L1 or L2 line mask in parallel. The
// cycle time is set by that compare plus the oldest-match priority pick
// across the row. A cycle item drains the head write when L2 has a free slot,
// then handles the head request; a probe item marks the oldest write on the
// same L2 line. Mask writes on the configuration channel are always taken.
// ----------------------------------------------------------------------------
module write_buffer_with_match_stall import wbms_pkg::*; (
  input logic        clk,
  input logic        rst,
  wbms_req_if.sink   req,
  wbms_rsp_if.source rsp,
  wbms_cfg_if.sink   cfg
);

  // configuration registers
  logic [ADDR_W-1:0] l1_mask;
  logic [ADDR_W-1:0] l2_mask;

  // buffer fill and output register
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  rsp_t             out_data;
  rsp_t             rsp_next;

  chain_ctrl_t ctrl;
  chain_stat_t stat;
  entry_t      load_ent;

  logic             acc;
  logic             is_cycle;
  logic             is_probe;
  logic             drain;
  logic             slot_left;
  logic             is_read;
  logic             is_write;
  logic             full;
  logic             read_hit;
  logic             wr;
  logic [DEPTH-1:0] l1_live;
  logic [DEPTH-1:0] l2_live;
  logic [DEPTH-1:0] post_vld;
  logic [DEPTH-1:0] free_first;
  logic [DEPTH-1:0] probe_first;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_mask <= L1_MASK_RESET;
      l2_mask <= L2_MASK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_L1_MASK: l1_mask <= cfg.data;
        REG_L2_MASK: l2_mask <= cfg.data;
        default:     ;
      endcase
    end
  end

  // accept while the output register is empty or being drained
  assign req.ready = !out_valid || rsp.ready;
  assign acc       = req.valid && req.ready;

  assign is_cycle = req.data.mode == MODE_CYCLE;
  assign is_probe = req.data.mode == MODE_PROBE;
  assign full     = count == CNT_W'(DEPTH);

  // drain the head write when L2 has any free slot
  assign drain     = is_cycle && (count != '0) && (req.data.l2_free_slots != '0);
  // a read still needs a slot after the drain took one
  assign slot_left = drain ? (req.data.l2_free_slots >= SLOT_W'(2))
                           : (req.data.l2_free_slots != '0);

  assign is_read  = is_cycle && req.data.req_valid && !req.data.req_is_write;
  assign is_write = is_cycle && req.data.req_valid && req.data.req_is_write;

  // read match only against writes left after the drain
  assign l1_live  = stat.l1_hit_vec & stat.vld_vec & ~(DEPTH'(drain));
  assign read_hit = |l1_live;

  // a drain always frees a slot, so a write stalls only on a full buffer
  assign wr = is_write && (drain || !full);

  // first free cell after the shift
  assign post_vld   = drain ? (stat.vld_vec >> 1) : stat.vld_vec;
  assign free_first = ~post_vld & ((post_vld << 1) | DEPTH'(1));

  // oldest live cell on the probed L2 line
  assign l2_live     = stat.l2_hit_vec & stat.vld_vec;
  assign probe_first = l2_live & ~(l2_live - DEPTH'(1));

  assign ctrl.shift    = acc && drain;
  assign ctrl.load_vec = (acc && wr) ? free_first : '0;
  assign ctrl.mark_vec = (acc && is_probe) ? probe_first : '0;

  assign load_ent.addr = req.data.req_addr;
  assign load_ent.tag  = req.data.req_tag;

  assign count_next = count - CNT_W'(drain) + CNT_W'(wr);

  always_comb begin
    rsp_next                    = '0;
    rsp_next.drain_valid        = drain;
    rsp_next.drain_tag          = drain ? stat.head.tag : '0;
    rsp_next.drain_addr         = drain ? stat.head.addr : '0;
    rsp_next.drain_cohe_release = drain && stat.head_cohe;
    rsp_next.req_forwarded      = is_read && !read_hit && slot_left;
    rsp_next.req_taken          = wr || (is_read && !read_hit && slot_left);
    rsp_next.stall_on_match     = is_read && read_hit;
    rsp_next.stall_full         = is_write && !wr;
    rsp_next.probe_hit          = is_probe && (l2_live != '0);
    rsp_next.occupancy          = OCC_W'(count_next);
  end

  wbms_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .load_ent (load_ent),
    .cmp_addr (req.data.req_addr),
    .l1_mask  (l1_mask),
    .l2_mask  (l2_mask),
    .stat     (stat)
  );

  // advance the fill count and hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data <= rsp_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(stat.vld_vec) == int'(count))
    else $error("fill count disagrees with occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (stat.vld_vec & (stat.vld_vec + DEPTH'(1))) == '0)
    else $error("occupied cells not packed at the head");

  a_full_no_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stall_full |-> !out_data.drain_valid)
    else $error("full stall reported in a draining cycle");

  a_probe_quiet: assert property (@(posedge clk) disable iff (rst)
    acc && is_probe |=> !out_data.drain_valid && !out_data.req_taken
                        && $stable(count))
    else $error("probe drained, took a request or changed the fill");
`endif

endmodule
